// ----- rtl/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg
// shared types, codes and widths of the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int WIDTH = 32;

   typedef enum logic [2:0] {
      FUNC_ADD  = 3'd0,
      FUNC_SUB  = 3'd1,
      FUNC_MUL  = 3'd2,
      FUNC_DIV  = 3'd3,
      FUNC_NORM = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_DEN = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL1,
      S_MUL2,
      S_COMB,
      S_GCD,
      S_DIV_INIT,
      S_DIV_NUM,
      S_DIV_DEN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] a_num;
      logic [31:0] a_den;
      logic [31:0] b_num;
      logic [31:0] b_den;
   } req_type;

   typedef struct packed {
      logic [31:0] res_num;
      logic [30:0] res_den;
      logic        a_less;
      logic        a_equal;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic mul1;
      logic mul2;
      logic comb;
      logic gcd_step;
      logic div_init;
      logic div_num_step;
      logic div_den_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic skip_gcd;
      logic gcd_done;
      logic div_last;
   } sts_type;

endpackage

// ----- rtl/rau_datapath.sv -----
// ----------------------------------------------------------------------------
// rau_datapath
// operand registers, products, binary gcd and restoring divider
// ----------------------------------------------------------------------------
module rau_datapath (
   input  logic              clock,
   input  rau_pkg::req_type  req_in,
   input  rau_pkg::cmd_type  cmd,
   output rau_pkg::sts_type  sts,
   output rau_pkg::rsp_type  rsp
);

   logic [2:0]  func_ff;
   logic        an_neg_ff, bn_neg_ff;
   logic [31:0] an_mag_ff, ad_mag_ff, bn_mag_ff, bd_mag_ff;
   logic        a_zero_ff, b_zero_ff;
   logic [63:0] p1_ff, p2_ff, p3_ff, p4_ff;
   logic        n_neg_ff;
   logic [63:0] n_mag_ff, d_mag_ff;
   logic        err_ff;
   logic        less_ff, equal_ff;
   logic [63:0] gx_ff, gy_ff;
   logic [6:0]  gsh_ff;
   logic [63:0] g_ff;
   logic [63:0] dq_ff;
   logic [64:0] drem_ff;
   logic [6:0]  dcnt_ff;
   logic [63:0] qn_ff;

   logic [31:0] an_mag, ad_mag, bn_mag, bd_mag;
   logic        an_neg, ad_neg, bn_neg, bd_neg, an_s, bn_s;
   logic [31:0] mx1, my1, mx2, my2;
   logic [63:0] prod1, prod2;
   logic        f_add, f_sub, f_mul, f_div;
   logic        t1_neg, t2_neg, s_neg;
   logic [64:0] s_mag;
   logic        d_neg_flag, n_neg_c, ovf;
   logic [63:0] lim;
   logic [64:0] trial;
   logic [63:0] gdiff;
   logic        gx_odd, gy_odd;

   always_comb begin
      an_neg = req_in.a_num[31];
      ad_neg = req_in.a_den[31];
      bn_neg = req_in.b_num[31];
      bd_neg = req_in.b_den[31];
      an_mag = an_neg ? (32'd0 - req_in.a_num) : req_in.a_num;
      ad_mag = ad_neg ? (32'd0 - req_in.a_den) : req_in.a_den;
      bn_mag = bn_neg ? (32'd0 - req_in.b_num) : req_in.b_num;
      bd_mag = bd_neg ? (32'd0 - req_in.b_den) : req_in.b_den;
      an_s = an_neg ^ ad_neg;
      bn_s = bn_neg ^ bd_neg;
   end

   // product select: mul1 forms an*bd, bn*ad; mul2 forms an*bn or ad*bn, ad*bd
   always_comb begin
      f_div = (func_ff == rau_pkg::FUNC_DIV);
      mx1 = cmd.mul1 ? an_mag_ff : (f_div ? ad_mag_ff : an_mag_ff);
      my1 = cmd.mul1 ? bd_mag_ff : bn_mag_ff;
      mx2 = cmd.mul1 ? bn_mag_ff : ad_mag_ff;
      my2 = cmd.mul1 ? ad_mag_ff : bd_mag_ff;
      prod1 = {32'd0, mx1} * {32'd0, my1};
      prod2 = {32'd0, mx2} * {32'd0, my2};
   end

   always_comb begin
      f_add = (func_ff == rau_pkg::FUNC_ADD);
      f_sub = (func_ff == rau_pkg::FUNC_SUB);
      f_mul = (func_ff == rau_pkg::FUNC_MUL);
      t1_neg = an_neg_ff && (p1_ff != 64'd0);
      t2_neg = (bn_neg_ff ^ f_sub) && (p2_ff != 64'd0);
      if (t1_neg == t2_neg) begin
         s_mag = {1'b0, p1_ff} + {1'b0, p2_ff};
         s_neg = t1_neg;
      end else if (p1_ff >= p2_ff) begin
         s_mag = {1'b0, p1_ff - p2_ff};
         s_neg = t1_neg;
      end else begin
         s_mag = {1'b0, p2_ff - p1_ff};
         s_neg = t2_neg;
      end
      d_neg_flag = f_div && bn_neg_ff && (bn_mag_ff != 32'd0);
   end

   always_comb begin
      gx_odd = gx_ff[0];
      gy_odd = gy_ff[0];
      gdiff = (gx_ff > gy_ff) ? (gx_ff - gy_ff) : (gy_ff - gx_ff);
      trial = {drem_ff[63:0], dq_ff[63]} - {1'b0, g_ff};
      sts.gcd_done = (gx_ff == gy_ff);
      sts.div_last = (dcnt_ff == 7'd63);
      sts.skip_gcd = err_ff || (n_mag_ff == 64'd0);
      lim = 64'd1 << (rau_pkg::WIDTH - 1);
   end

   logic diff_neg_c;
   logic [63:0] diff_mag_c;
   always_comb begin
      // a - b for comparison: an*bd - bn*ad with true signs
      if ((an_neg_ff && (p1_ff != 0)) == (bn_neg_ff && (p3_ff != 0))) begin
         diff_mag_c = (p1_ff >= p3_ff) ? p1_ff - p3_ff : p3_ff - p1_ff;
         diff_neg_c = (p1_ff >= p3_ff) ? (an_neg_ff && p1_ff != 0)
                                       : !(bn_neg_ff && p3_ff != 0);
      end else begin
         diff_mag_c = p1_ff | p3_ff;
         diff_neg_c = an_neg_ff && (p1_ff != 0);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff   <= (req_in.func > 3'd4) ? rau_pkg::FUNC_NORM : req_in.func;
         an_neg_ff <= an_s;
         bn_neg_ff <= bn_s;
         an_mag_ff <= an_mag;
         ad_mag_ff <= ad_mag;
         bn_mag_ff <= bn_mag;
         bd_mag_ff <= bd_mag;
         a_zero_ff <= (ad_mag == 32'd0);
         b_zero_ff <= (bd_mag == 32'd0);
      end
      if (cmd.mul1) begin
         p1_ff <= prod1;
         p2_ff <= prod2;
         p3_ff <= prod2;
      end
      if (cmd.mul2) begin
         less_ff  <= !a_zero_ff && !b_zero_ff && diff_neg_c && (diff_mag_c != 0);
         equal_ff <= !a_zero_ff && !b_zero_ff && (diff_mag_c == 0);
         if (f_mul) p1_ff <= prod1;
         if (!f_add && !f_sub) p2_ff <= 64'd0;
         p4_ff <= f_div ? prod1 : prod2;
      end
      if (cmd.comb) begin
         if (f_add || f_sub) begin
            n_neg_ff <= s_neg;
            n_mag_ff <= s_mag[63:0];
            d_mag_ff <= p4_ff;
            err_ff   <= a_zero_ff || b_zero_ff || s_mag[64];
         end else if (f_mul || f_div) begin
            n_neg_ff <= ((f_mul ? (an_neg_ff ^ bn_neg_ff) : an_neg_ff) ^ d_neg_flag)
                        && (p1_ff != 0);
            n_mag_ff <= p1_ff;
            d_mag_ff <= p4_ff;
            err_ff   <= a_zero_ff || b_zero_ff || (f_div && bn_mag_ff == 32'd0);
         end else begin
            n_neg_ff <= an_neg_ff && (an_mag_ff != 0);
            n_mag_ff <= {32'd0, an_mag_ff};
            d_mag_ff <= {32'd0, ad_mag_ff};
            err_ff   <= a_zero_ff;
         end
         gsh_ff <= 7'd0;
      end
      if (cmd.comb) begin
         gx_ff <= (f_add || f_sub) ? s_mag[63:0] : (f_mul || f_div) ? p1_ff
                  : {32'd0, an_mag_ff};
         gy_ff <= (f_add || f_sub || f_mul || f_div) ? p4_ff : {32'd0, ad_mag_ff};
      end
      if (cmd.gcd_step) begin
         if (!gx_odd && !gy_odd) begin
            gx_ff <= gx_ff >> 1;
            gy_ff <= gy_ff >> 1;
            gsh_ff <= gsh_ff + 7'd1;
         end else if (!gx_odd) begin
            gx_ff <= gx_ff >> 1;
         end else if (!gy_odd) begin
            gy_ff <= gy_ff >> 1;
         end else if (gx_ff > gy_ff) begin
            gx_ff <= gdiff;
         end else begin
            gy_ff <= gdiff;
         end
      end
      if (cmd.div_init) begin
         g_ff    <= gx_ff << gsh_ff[5:0];
         dq_ff   <= n_mag_ff;
         drem_ff <= 65'd0;
         dcnt_ff <= 7'd0;
      end
      if (cmd.div_num_step || cmd.div_den_step) begin
         if (cmd.div_num_step && sts.div_last) begin
            qn_ff   <= {dq_ff[62:0], !trial[64]};
            dq_ff   <= d_mag_ff;
            drem_ff <= 65'd0;
         end else begin
            if (!trial[64]) drem_ff <= trial;
            else drem_ff <= {drem_ff[63:0], dq_ff[63]};
            dq_ff <= {dq_ff[62:0], !trial[64]};
         end
         dcnt_ff <= sts.div_last ? 7'd0 : dcnt_ff + 7'd1;
      end
      if (cmd.finish) begin
         if (sts.skip_gcd) begin
            qn_ff <= 64'd0;
            dq_ff <= 64'd1;
         end
      end
   end

   // p4 holds a denominator product; for norm gy holds ad directly
   logic [63:0] fn, fd;
   always_comb begin
      fn = qn_ff;
      fd = dq_ff;
      ovf = (n_neg_ff ? (fn > lim) : (fn >= lim)) || (fd >= lim);
      n_neg_c = n_neg_ff && (fn != 0);
      rsp.a_less  = less_ff;
      rsp.a_equal = equal_ff;
      if (err_ff || d_mag_ff == 64'd0) begin
         rsp.status  = rau_pkg::ST_ZERO_DEN;
         rsp.res_num = 32'd0;
         rsp.res_den = 31'd0;
      end else if (ovf) begin
         rsp.status  = rau_pkg::ST_OVERFLOW;
         rsp.res_num = 32'd0;
         rsp.res_den = 31'd0;
      end else begin
         rsp.status  = rau_pkg::ST_OK;
         rsp.res_num = n_neg_c ? (32'd0 - fn[31:0]) : fn[31:0];
         rsp.res_den = fd[30:0];
      end
   end

endmodule

// ----- rtl/rau_control.sv -----
// ----------------------------------------------------------------------------
// rau_control
// sequencer for load, products, gcd loop and the two divisions
// ----------------------------------------------------------------------------
module rau_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  rau_pkg::sts_type sts,
   output rau_pkg::cmd_type cmd,
   output logic             busy,
   output logic             done
);

   rau_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= rau_pkg::S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = (state_ff != rau_pkg::S_IDLE);
      done = 1'b0;
      unique case (state_ff)
         rau_pkg::S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = rau_pkg::S_MUL1;
            end
         end
         rau_pkg::S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = rau_pkg::S_MUL2;
         end
         rau_pkg::S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = rau_pkg::S_COMB;
         end
         rau_pkg::S_COMB: begin
            cmd.comb = 1'b1;
            state_in = rau_pkg::S_GCD;
         end
         rau_pkg::S_GCD: begin
            if (sts.skip_gcd) begin
               state_in = rau_pkg::S_DONE;
               cmd.finish = 1'b1;
            end else if (sts.gcd_done) begin
               state_in = rau_pkg::S_DIV_INIT;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         rau_pkg::S_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in = rau_pkg::S_DIV_NUM;
         end
         rau_pkg::S_DIV_NUM: begin
            cmd.div_num_step = 1'b1;
            if (sts.div_last) state_in = rau_pkg::S_DIV_DEN;
         end
         rau_pkg::S_DIV_DEN: begin
            cmd.div_den_step = 1'b1;
            if (sts.div_last) state_in = rau_pkg::S_DONE;
         end
         rau_pkg::S_DONE: begin
            done = 1'b1;
            state_in = rau_pkg::S_IDLE;
         end
         default: state_in = rau_pkg::S_IDLE;
      endcase
   end

endmodule

// ----- rtl/rational_arithmetic_unit_core.sv -----
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core
// fraction add, subtract, multiply, divide and normalize with gcd reduction
//
// channel   ports                      handshake
// request   start, busy, req_data      taken when start and not busy
// result    rsp_valid, rsp_data        one cycle strobe, no back pressure
//
// one request at a time. the binary gcd loop over 64 bits and two 64-step
// restoring divisions make up the bulk of the work. a zero numerator
// or an error skips gcd and divisions.
// synchronous active high reset returns the sequencer to idle.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rau_pkg::req_type req_data,
   output logic             rsp_valid,
   output rau_pkg::rsp_type rsp_data
);

   rau_pkg::cmd_type cmd;
   rau_pkg::sts_type sts;

   rau_control u_control (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy),
      .done  (rsp_valid)
   );

   rau_datapath u_datapath (
      .clock  (clock),
      .req_in (req_data),
      .cmd    (cmd),
      .sts    (sts),
      .rsp    (rsp_data)
   );

   a_no_start_when_busy_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !busy) else $error("load while busy");
   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy after result");
   a_status_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != rau_pkg::ST_OK |-> rsp_data.res_den == 31'd0)
      else $error("error result not cleared");

endmodule

// ----- bench/rational_arithmetic_unit_core_tb.sv -----
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core_tb
// self-checking bench: directed table then random fractions, each response
// compared field by field with a behavioral fraction calculator
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 400;
   localparam int RANDOM_COUNT = 1830;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   rau_pkg::req_type req_data;
   logic             rsp_valid;
   rau_pkg::rsp_type rsp_data;

   rau_pkg::rsp_type expected_q[$];
   int               mismatch_count;
   int               idle_cycles;
   int               sender_idle_pct;

   rational_arithmetic_unit_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] gcd_u64(logic [63:0] x, logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic rau_pkg::rsp_type compute_fraction(rau_pkg::req_type r);
      rau_pkg::rsp_type   o;
      logic signed [65:0] an, ad, bn, bd, num, den, diff, lim, g;
      logic [63:0]        nm, dm, gg;
      logic               a_zero, b_zero;
      rau_pkg::func_type  f;
      o = '0;
      an = 66'(signed'(r.a_num));
      ad = 66'(signed'(r.a_den));
      bn = 66'(signed'(r.b_num));
      bd = 66'(signed'(r.b_den));
      a_zero = (ad == 0);
      b_zero = (bd == 0);
      if (ad < 0) begin
         an = -an; ad = -ad;
      end
      if (bd < 0) begin
         bn = -bn; bd = -bd;
      end
      if (!a_zero && !b_zero) begin
         diff = an * bd - bn * ad;
         o.a_less = diff < 0;
         o.a_equal = diff == 0;
      end
      f = rau_pkg::func_type'(r.func);
      case (f)
         rau_pkg::FUNC_ADD: begin num = an * bd + bn * ad; den = ad * bd; end
         rau_pkg::FUNC_SUB: begin num = an * bd - bn * ad; den = ad * bd; end
         rau_pkg::FUNC_MUL: begin num = an * bn; den = ad * bd; end
         rau_pkg::FUNC_DIV: begin num = an * bd; den = ad * bn; end
         default: begin num = an; den = ad; b_zero = 1'b0; end
      endcase
      lim = 66'sd1 <<< 31;
      if (a_zero || b_zero || den == 0) begin
         o.status = rau_pkg::ST_ZERO_DEN;
      end else begin
         if (den < 0) begin
            num = -num; den = -den;
         end
         if (num == 0) begin
            den = 1;
         end else begin
            nm = 64'(num < 0 ? -num : num);
            dm = 64'(den);
            gg = gcd_u64(nm, dm);
            g = 66'(gg);
            num = num / g;
            den = den / g;
         end
         if (num >= lim || num < -lim || den >= lim) begin
            o.status = rau_pkg::ST_OVERFLOW;
         end else begin
            o.res_num = num[31:0];
            o.res_den = den[30:0];
            o.status = rau_pkg::ST_OK;
         end
      end
      return o;
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'(signed'($urandom_range(0, 6)) - 3);
         3: return 32'($urandom_range(0, 2000)) - 32'd1000;
         4: return 32'($urandom_range(0, 65535)) - 32'd32768;
         5: return 32'h0;
         default: return $urandom();
      endcase
   endfunction

   function automatic void queue_expected(rau_pkg::rsp_type e);
      expected_q.insert(expected_q.size(), e);
   endfunction

   task automatic send_request(rau_pkg::req_type r);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      queue_expected(compute_fraction(r));
   endtask

   always @(posedge clock) begin
      if (rsp_valid && !reset) begin
         if (expected_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response %p", rsp_data);
         end else if (rsp_data !== expected_q[0]) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("mismatch: expected %p actual %p", expected_q[0], rsp_data);
            void'(expected_q.pop_front());
         end else begin
            void'(expected_q.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[rational_arithmetic_unit_core] ERROR");
         $finish;
      end
   end

   typedef struct {
      rau_pkg::req_type stim;
      logic             has_golden;
      rau_pkg::rsp_type golden;
   } table_row;

   table_row directed[] = '{
      '{'{rau_pkg::FUNC_ADD, 32'd1, 32'd2, 32'd1, 32'd3}, 1'b1,
        '{32'd5, 31'd6, 1'b0, 1'b0, rau_pkg::ST_OK}},
      '{'{rau_pkg::FUNC_SUB, 32'd1, 32'd2, 32'd1, 32'd2}, 1'b1,
        '{32'd0, 31'd1, 1'b0, 1'b1, rau_pkg::ST_OK}},
      '{'{rau_pkg::FUNC_MUL, 32'd2, 32'd3, 32'd3, 32'd4}, 1'b1,
        '{32'd1, 31'd2, 1'b1, 1'b0, rau_pkg::ST_OK}},
      '{'{rau_pkg::FUNC_DIV, 32'd1, 32'd2, 32'd0, 32'd3}, 1'b1,
        '{32'd0, 31'd0, 1'b0, 1'b0, rau_pkg::ST_ZERO_DEN}},
      '{'{rau_pkg::FUNC_NORM, 32'd4, -32'sd8, 32'd1, 32'd0}, 1'b1,
        '{-32'sd1, 31'd2, 1'b0, 1'b0, rau_pkg::ST_OK}},
      '{'{rau_pkg::FUNC_ADD, 32'd1, 32'd0, 32'd1, 32'd1}, 1'b1,
        '{32'd0, 31'd0, 1'b0, 1'b0, rau_pkg::ST_ZERO_DEN}},
      '{'{rau_pkg::FUNC_SUB, 32'd1, 32'd1, 32'd1, 32'd0}, 1'b1,
        '{32'd0, 31'd0, 1'b0, 1'b0, rau_pkg::ST_ZERO_DEN}},
      '{'{rau_pkg::FUNC_NORM, 32'd1, 32'd0, 32'd1, 32'd1}, 1'b1,
        '{32'd0, 31'd0, 1'b0, 1'b0, rau_pkg::ST_ZERO_DEN}},
      '{'{rau_pkg::FUNC_NORM, 32'h8000_0000, -32'sd1, 32'd1, 32'd1}, 1'b1,
        '{32'd0, 31'd0, 1'b0, 1'b0, rau_pkg::ST_OVERFLOW}},
      '{'{rau_pkg::FUNC_MUL, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1}, 1'b1,
        '{32'd0, 31'd0, 1'b0, 1'b1, rau_pkg::ST_OVERFLOW}},
      '{'{rau_pkg::FUNC_NORM, 32'd0, -32'sd5, 32'd0, 32'd0}, 1'b1,
        '{32'd0, 31'd1, 1'b0, 1'b0, rau_pkg::ST_OK}},
      '{'{3'd5, 32'd6, 32'd4, 32'd1, 32'd1}, 1'b0, '0},
      '{'{3'd6, -32'sd6, 32'd9, 32'd1, 32'd1}, 1'b0, '0},
      '{'{3'd7, 32'h8000_0000, 32'h8000_0000, 32'd3, 32'd7}, 1'b0, '0},
      '{'{rau_pkg::FUNC_ADD, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
          32'h8000_0000}, 1'b0, '0},
      '{'{rau_pkg::FUNC_SUB, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
          32'h7fff_ffff}, 1'b0, '0},
      '{'{rau_pkg::FUNC_MUL, 32'h8000_0000, 32'd1, -32'sd1, 32'd1}, 1'b0, '0},
      '{'{rau_pkg::FUNC_DIV, 32'h8000_0000, 32'hffff_ffff, 32'h8000_0000, 32'd1},
        1'b0, '0},
      '{'{rau_pkg::FUNC_DIV, -32'sd3, 32'd4, 32'd5, -32'sd6}, 1'b0, '0},
      '{'{rau_pkg::FUNC_ADD, -32'sd1, 32'd3, -32'sd1, 32'd3}, 1'b0, '0},
      '{'{rau_pkg::FUNC_NORM, 32'hffff_ffff, 32'hffff_ffff, 32'd0, 32'd0}, 1'b0, '0}
   };

   initial begin
      rau_pkg::req_type r;
      rau_pkg::rsp_type gold;
      int drain;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      mismatch_count = 0;
      idle_cycles = 0;
      sender_idle_pct = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) begin
         if (directed[i].has_golden) begin
            gold = compute_fraction(directed[i].stim);
            if (gold !== directed[i].golden) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("table row %0d: typed %p computed %p", i, directed[i].golden, gold);
            end
         end
         send_request(directed[i].stim);
      end
      for (int n = 0; n < RANDOM_COUNT; n++) begin
         case ((n * 4) / RANDOM_COUNT)
            0: sender_idle_pct = 0;
            1: sender_idle_pct = 81;
            2: sender_idle_pct = 0;
            default: sender_idle_pct = 20;
         endcase
         r.func = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
         r.a_num = pick_value();
         r.a_den = pick_value();
         r.b_num = pick_value();
         r.b_den = pick_value();
         send_request(r);
      end
      start <= 1'b0;
      drain = 0;
      while (expected_q.size() != 0 && drain < WATCHDOG_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_q.size() == 0) begin
         $display("[rational_arithmetic_unit_core] OK");
      end else begin
         $display("[rational_arithmetic_unit_core] ERROR");
      end
      $finish;
   end

endmodule
